### hdl/barometric_pressure_compensation_top_assert.svh
// assertion macros for the pressure compensation checker
// expects signals named clk and rst_n in the scope of use
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bpc_pkg.sv
// shared types, constants and the divider step for the pressure compensation
// no dependencies
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int OVERSAMPLING = 0;

  // configuration map
  localparam int NUM_REGS = 5;
  localparam int ADDR_W   = 5;
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;

  localparam logic [15:0] B7_SCALE = 16'(50000 >> OVERSAMPLING);

  // pipeline stage map
  localparam int DIV_STEPS     = 32;
  localparam int ST_SUB        = 0;
  localparam int ST_MUL1       = ST_SUB + 1;
  localparam int ST_DEN        = ST_MUL1 + 1;
  localparam int ST_DIV1_FIRST = ST_DEN + 1;
  localparam int ST_DIV1_LAST  = ST_DIV1_FIRST + DIV_STEPS - 1;
  localparam int ST_B5         = ST_DIV1_LAST + 1;
  localparam int ST_T          = ST_B5 + 1;
  localparam int ST_SQM        = ST_T + 1;
  localparam int ST_SQ         = ST_SQM + 1;
  localparam int ST_MB         = ST_SQ + 1;
  localparam int ST_B3         = ST_MB + 1;
  localparam int ST_B4         = ST_B3 + 1;
  localparam int ST_B7         = ST_B4 + 1;
  localparam int ST_DIV2_FIRST = ST_B7 + 1;
  localparam int ST_DIV2_LAST  = ST_DIV2_FIRST + DIV_STEPS - 1;
  localparam int ST_P          = ST_DIV2_LAST + 1;
  localparam int ST_UU         = ST_P + 1;
  localparam int ST_X          = ST_UU + 1;
  localparam int ST_PRESS      = ST_X + 1;
  localparam int N_ST          = ST_PRESS + 1;

  typedef struct packed {
    logic               fault;
    logic [18:0]        up;
    logic signed [16:0] d1;
    logic signed [33:0] m1;
    logic signed [19:0] x1t;
    logic               qneg;
    logic [31:0]        dq;
    logic [19:0]        rem;
    logic [19:0]        dsr;
    logic signed [27:0] b5;
    logic signed [15:0] t;
    logic signed [27:0] b6;
    logic [55:0]        sqm;
    logic signed [43:0] mac2;
    logic signed [43:0] mac3;
    logic [43:0]        sq;
    logic signed [60:0] mb2;
    logic signed [60:0] mb1;
    logic [31:0]        b3;
    logic [31:0]        u;
    logic [16:0]        b4;
    logic [31:0]        b7a;
    logic               b7hi;
    logic [32:0]        p;
    logic [49:0]        uu;
    logic [45:0]        m7;
    logic [45:0]        px1;
    logic signed [30:0] px2;
    logic [17:0]        press;
  } item_t;

  // one restoring step: next quotient bit into dq, remainder kept below dsr
  function automatic item_t div_step(input item_t s);
    item_t       o;
    logic [20:0] r;
    logic [20:0] diff;
    o    = s;
    r    = {s.rem, s.dq[31]};
    diff = r - {1'b0, s.dsr};
    if (r >= {1'b0, s.dsr}) begin
      o.rem = diff[19:0];
      o.dq  = {s.dq[30:0], 1'b1};
    end else begin
      o.rem = r[19:0];
      o.dq  = {s.dq[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

### hdl/bpc_if.sv
// valid/ready channel interfaces for raw readings and compensated results
// no dependencies
`timescale 1ns / 1ps

interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [18:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_decideg;
  logic [17:0]        pressure_pa;
  logic               divide_fault;
  modport source (output valid, temperature_decideg, pressure_pa, divide_fault,
                  input ready);
  modport sink   (input valid, temperature_decideg, pressure_pa, divide_fault,
                  output ready);
endinterface

### hdl/barometric_pressure_compensation_top.sv
// Barometric pressure compensation. Takes one beat of raw temperature and raw
// pressure per clock while the skid entry is empty, and returns temperature
// in 0.1 C and pressure in Pa. Each beat passes through the 79-stage pipeline
// and then the output register; two 32-stage restoring dividers (one quotient
// bit per stage) take up most of the pipeline.
// A two-entry output (register plus skid) keeps the input open while a result
// waits, until a second result fills the skid entry. Calibration words sit in
// five 32-bit registers at byte addresses 0x00 to 0x10; the user must write
// them only while the block is idle, as the block itself does not enforce it.
// depends on bpc_pkg and bpc_if
`timescale 1ns / 1ps

module barometric_pressure_compensation_top
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bpc_in_if.sink            in_bus,
  bpc_out_if.source         out_bus,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] coef_r [NUM_REGS];
  logic [2:0]  reg_idx;

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  item_t           st_r   [N_ST];
  item_t           st_nxt [N_ST];
  logic [N_ST-1:0] v_r;

  item_t out_d_r, skid_d_r;
  logic  out_v_r, skid_v_r;
  logic  adv, take;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) coef_r[i] <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_AC1_AC2: coef_r[REG_AC1_AC2] <= pwdata;
        REG_AC3_AC4: coef_r[REG_AC3_AC4] <= pwdata;
        REG_AC5_AC6: coef_r[REG_AC5_AC6] <= pwdata;
        REG_B1_B2:   coef_r[REG_B1_B2]   <= pwdata;
        REG_MC_MD:   coef_r[REG_MC_MD]   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_AC1_AC2: prdata = coef_r[REG_AC1_AC2];
      REG_AC3_AC4: prdata = coef_r[REG_AC3_AC4];
      REG_AC5_AC6: prdata = coef_r[REG_AC5_AC6];
      REG_B1_B2:   prdata = coef_r[REG_B1_B2];
      REG_MC_MD:   prdata = coef_r[REG_MC_MD];
      default:     prdata = '0;
    endcase
  end

  assign ac1 = $signed(coef_r[REG_AC1_AC2][31:16]);
  assign ac2 = $signed(coef_r[REG_AC1_AC2][15:0]);
  assign ac3 = $signed(coef_r[REG_AC3_AC4][31:16]);
  assign ac4 = coef_r[REG_AC3_AC4][15:0];
  assign ac5 = coef_r[REG_AC5_AC6][31:16];
  assign ac6 = coef_r[REG_AC5_AC6][15:0];
  assign b1  = $signed(coef_r[REG_B1_B2][31:16]);
  assign b2  = $signed(coef_r[REG_B1_B2][15:0]);
  assign mc  = $signed(coef_r[REG_MC_MD][31:16]);
  assign md  = $signed(coef_r[REG_MC_MD][15:0]);

  // stage logic
  always_comb begin
    logic signed [19:0] x1v;
    logic signed [20:0] den_v;
    logic signed [26:0] num_v;
    logic [26:0]        num_mag;
    logic [20:0]        den_mag;
    logic signed [27:0] qv;
    logic signed [27:0] x2v;
    logic signed [24:0] tt;
    logic signed [49:0] x3a;
    logic signed [53:0] vv;
    logic signed [45:0] sumb;
    logic signed [45:0] x3bv;
    logic [47:0]        prod4;
    logic [47:0]        prod7;
    logic [31:0]        b7v;
    logic [61:0]        prx;
    logic signed [46:0] nm;
    logic signed [47:0] corr;
    logic signed [47:0] adj;
    logic signed [49:0] pres;

    st_nxt[ST_SUB] = st_r[ST_SUB];
    for (int k = 1; k < N_ST; k++) st_nxt[k] = st_r[k-1];

    // temperature front end
    st_nxt[ST_SUB].fault = 1'b0;
    st_nxt[ST_SUB].up    = in_bus.raw_pressure;
    st_nxt[ST_SUB].d1    = 17'($signed({1'b0, in_bus.raw_temperature})
                               - $signed({1'b0, ac6}));

    st_nxt[ST_MUL1].m1 = st_r[ST_MUL1-1].d1 * $signed({1'b0, ac5});

    x1v     = 20'(st_r[ST_DEN-1].m1 >>> 15);
    den_v   = x1v + md;
    num_v   = {mc, 11'b0};
    num_mag = 27'(num_v[26] ? -num_v : num_v);
    den_mag = 21'(den_v[20] ? -den_v : den_v);
    st_nxt[ST_DEN].x1t   = x1v;
    st_nxt[ST_DEN].qneg  = num_v[26] ^ den_v[20];
    st_nxt[ST_DEN].fault = (den_v == '0);
    st_nxt[ST_DEN].dq    = {5'b0, num_mag};
    st_nxt[ST_DEN].dsr   = den_mag[19:0];
    st_nxt[ST_DEN].rem   = '0;

    for (int k = ST_DIV1_FIRST; k <= ST_DIV1_LAST; k++) st_nxt[k] = div_step(st_r[k-1]);

    // b5 and temperature
    qv  = $signed({1'b0, st_r[ST_B5-1].dq[26:0]});
    x2v = st_r[ST_B5-1].qneg ? -qv : qv;
    st_nxt[ST_B5].b5 = st_r[ST_B5-1].x1t + x2v;

    tt = 25'((st_r[ST_T-1].b5 + 28'sd8) >>> 4);
    if (tt > 25'sd32767)       st_nxt[ST_T].t = 16'sh7fff;
    else if (tt < -25'sd32768) st_nxt[ST_T].t = -16'sh8000;
    else                       st_nxt[ST_T].t = tt[15:0];
    st_nxt[ST_T].b6 = st_r[ST_T-1].b5 - 28'sd4000;

    // pressure products
    st_nxt[ST_SQM].sqm  = st_r[ST_SQM-1].b6 * st_r[ST_SQM-1].b6;
    st_nxt[ST_SQM].mac2 = ac2 * st_r[ST_SQM-1].b6;
    st_nxt[ST_SQM].mac3 = ac3 * st_r[ST_SQM-1].b6;

    st_nxt[ST_SQ].sq   = 44'(st_r[ST_SQ-1].sqm >> 12);
    st_nxt[ST_SQ].mac2 = st_r[ST_SQ-1].mac2 >>> 11;
    st_nxt[ST_SQ].mac3 = st_r[ST_SQ-1].mac3 >>> 13;

    st_nxt[ST_MB].mb2 = b2 * $signed({1'b0, st_r[ST_MB-1].sq});
    st_nxt[ST_MB].mb1 = b1 * $signed({1'b0, st_r[ST_MB-1].sq});

    // b3 rounds toward zero, the b4 operand toward minus infinity
    x3a = 50'((st_r[ST_B3-1].mb2 >>> 11) + st_r[ST_B3-1].mac2);
    vv  = (($signed({ac1, 2'b00}) + x3a) <<< OVERSAMPLING) + 54'sd2;
    st_nxt[ST_B3].b3 = vv[53] ? 32'((vv + 54'sd3) >>> 2) : 32'(vv >>> 2);
    sumb = 46'(st_r[ST_B3-1].mac3 + (st_r[ST_B3-1].mb1 >>> 16) + 46'sd2);
    x3bv = sumb >>> 2;
    st_nxt[ST_B3].u = 32'(x3bv + 46'sd32768);

    prod4 = ac4 * st_r[ST_B4-1].u;
    st_nxt[ST_B4].b4  = prod4[31:15];
    st_nxt[ST_B4].b7a = 32'({13'b0, st_r[ST_B4-1].up} - st_r[ST_B4-1].b3);

    prod7 = st_r[ST_B7-1].b7a * B7_SCALE;
    b7v   = prod7[31:0];
    st_nxt[ST_B7].b7hi  = b7v[31];
    st_nxt[ST_B7].dq    = b7v[31] ? b7v : {b7v[30:0], 1'b0};
    st_nxt[ST_B7].dsr   = {3'b0, st_r[ST_B7-1].b4};
    st_nxt[ST_B7].rem   = '0;
    st_nxt[ST_B7].fault = st_r[ST_B7-1].fault | (st_r[ST_B7-1].b4 == '0);

    for (int k = ST_DIV2_FIRST; k <= ST_DIV2_LAST; k++) st_nxt[k] = div_step(st_r[k-1]);

    // final pressure correction
    st_nxt[ST_P].p = st_r[ST_P-1].b7hi ? {st_r[ST_P-1].dq, 1'b0} : {1'b0, st_r[ST_P-1].dq};

    st_nxt[ST_UU].uu = st_r[ST_UU-1].p[32:8] * st_r[ST_UU-1].p[32:8];
    st_nxt[ST_UU].m7 = st_r[ST_UU-1].p * 13'd7357;

    prx = st_r[ST_X-1].uu * 12'd3038;
    st_nxt[ST_X].px1 = prx[61:16];
    nm  = -$signed({1'b0, st_r[ST_X-1].m7});
    st_nxt[ST_X].px2 = 31'(nm >>> 16);

    corr = $signed({2'b0, st_r[ST_PRESS-1].px1}) + st_r[ST_PRESS-1].px2 + 48'sd3791;
    adj  = corr >>> 4;
    pres = $signed({17'b0, st_r[ST_PRESS-1].p}) + adj;
    if (pres < 50'sd0)           st_nxt[ST_PRESS].press = '0;
    else if (pres > 50'sd262143) st_nxt[ST_PRESS].press = '1;
    else                         st_nxt[ST_PRESS].press = pres[17:0];
    if (st_r[ST_PRESS-1].fault) begin
      st_nxt[ST_PRESS].press = '0;
      st_nxt[ST_PRESS].t     = '0;
    end
  end

  // pipeline advances as a whole unless the skid entry is occupied
  assign adv          = !skid_v_r;
  assign in_bus.ready = adv;
  assign take         = out_v_r && out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[N_ST-2:0], in_bus.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N_ST; k++) st_r[k] <= st_nxt[k];
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (v_r[N_ST-1]) begin
      if (!out_v_r || take) out_v_r <= 1'b1;
      else                  skid_v_r <= 1'b1;
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) out_d_r <= skid_d_r;
    end else if (v_r[N_ST-1]) begin
      if (!out_v_r || take) out_d_r  <= st_r[N_ST-1];
      else                  skid_d_r <= st_r[N_ST-1];
    end
  end

  assign out_bus.valid               = out_v_r;
  assign out_bus.temperature_decideg = out_d_r.t;
  assign out_bus.pressure_pa         = out_d_r.press;
  assign out_bus.divide_fault        = out_d_r.fault;

endmodule

### hdl/bpc_checker.sv
// port-level checks on the pressure compensation top, bound to it below
// depends on barometric_pressure_compensation_top_assert.svh
`timescale 1ns / 1ps
`include "barometric_pressure_compensation_top_assert.svh"

module bpc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a waiting result beat holds until taken
  `BPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

  // input only closes while a result is waiting
  `BPC_ASSERT_NOW(a_stall_needs_result, !in_ready, out_valid, "input closed with no result")

  // input closes only after the output stalled in the previous cycle
  `BPC_ASSERT_NOW(a_stall_cause, !in_ready, $past(out_valid && !out_ready),
                  "input closed without an output stall")

  // a beat offered while the input is closed means a result was already waiting
  `BPC_ASSERT_NOW(a_no_accept_closed, in_valid && !in_ready, $past(out_valid),
                  "input closed while output was empty")

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready)
);

### tb/tb.sv
// self-checking bench for the barometric pressure compensation block
// depends on bpc_pkg, bpc_if and barometric_pressure_compensation_top
`timescale 1ns / 1ps

module tb;
  import bpc_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [15:0] temp;
    logic [17:0]        press;
    logic               fault;
  } reading_t;

  typedef struct {
    int          set;
    logic [15:0] ut;
    logic [18:0] up;
    bit          typed;
    reading_t    want;
  } row_t;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 120;
  localparam u64_t MASK32 = 64'hFFFF_FFFF;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  bpc_in_if  in_bus ();
  bpc_out_if out_bus ();

  barometric_pressure_compensation_top dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [31:0] coef [NUM_REGS];
  logic [31:0] coef_sets [6][NUM_REGS];
  reading_t    pending [$];
  int          errors;
  int          cycles = 0;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // integer compensation of one reading against the current calibration words
  function automatic reading_t compensate(input logic [15:0] ut_in, input logic [18:0] up_in);
    reading_t r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
    longint x1, x2, x3, b3, b5, b6, sq, t, p, press, den;
    u64_t u, b4, b7;
    ac1 = longint'($signed(coef[REG_AC1_AC2][31:16]));
    ac2 = longint'($signed(coef[REG_AC1_AC2][15:0]));
    ac3 = longint'($signed(coef[REG_AC3_AC4][31:16]));
    ac4 = longint'(coef[REG_AC3_AC4][15:0]);
    ac5 = longint'(coef[REG_AC5_AC6][31:16]);
    ac6 = longint'(coef[REG_AC5_AC6][15:0]);
    b1  = longint'($signed(coef[REG_B1_B2][31:16]));
    b2  = longint'($signed(coef[REG_B1_B2][15:0]));
    mc  = longint'($signed(coef[REG_MC_MD][31:16]));
    md  = longint'($signed(coef[REG_MC_MD][15:0]));
    ut  = longint'(ut_in);
    r.temp = '0; r.press = '0; r.fault = 1'b1;
    x1  = ((ut - ac6) * ac5) >>> 15;
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t  = (b5 + 8) >>> 4;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << OVERSAMPLING) + 2) / 4;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    u  = u64_t'(x3 + 32768) & MASK32;
    b4 = ((u64_t'(ac4) * u) & MASK32) >> 15;
    if (b4 == 0) return r;
    b7 = (u64_t'(up_in) - u64_t'(b3)) & MASK32;
    b7 = (b7 * u64_t'(50000 >> OVERSAMPLING)) & MASK32;
    if (b7 < 64'h8000_0000) p = longint'((b7 * 2) / b4);
    else p = longint'((b7 / b4) * 2);
    u  = u64_t'(p >>> 8);
    x1 = longint'(((u * u) * 3038) >> 16);
    x2 = (-7357 * p) >>> 16;
    press = p + ((x1 + x2 + 3791) >>> 4);
    if (press < 0) press = 0;
    if (press > 262143) press = 262143;
    r.temp  = 16'(t);
    r.press = 18'(press);
    r.fault = 1'b0;
    return r;
  endfunction

  // setup then access phase, written at the edge where penable and pready are high
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = ADDR_W'(4 * idx); pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    coef[idx] = val;
  endtask

  task automatic settle_and_load(input logic [31:0] regs [NUM_REGS]);
    wait (pending.size() == 0);
    repeat (DRAIN) @(posedge clk);
    write_reg(REG_AC1_AC2, regs[0]);
    write_reg(REG_AC3_AC4, regs[1]);
    write_reg(REG_AC5_AC6, regs[2]);
    write_reg(REG_B1_B2, regs[3]);
    write_reg(REG_MC_MD, regs[4]);
  endtask

  // one beat on the input; valid stays high across back-to-back beats
  task automatic send(input logic [15:0] ut, input logic [18:0] up, input bit typed,
                      input reading_t want);
    int gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.raw_temperature = ut;
    in_bus.raw_pressure = up;
    do @(posedge clk); while (!in_bus.ready);
    pending.push_back(typed ? want : compensate(ut, up));
  endtask

  task automatic park_input();
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  // result side: random stall bursts
  initial begin
    int stall;
    stall = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_bus.ready = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18) - 1;
        out_bus.ready = 1'b0;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    reading_t w;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        w = pending.pop_front();
        if (out_bus.divide_fault !== w.fault)
          report("divide_fault", out_bus.divide_fault, w.fault);
        if (out_bus.temperature_decideg !== w.temp)
          report("temperature_decideg", out_bus.temperature_decideg, w.temp);
        if (out_bus.pressure_pa !== w.press)
          report("pressure_pa", out_bus.pressure_pa, w.press);
      end
    end
  end

  function automatic reading_t rd(input logic signed [15:0] t, input logic [17:0] p,
                                  input logic f);
    reading_t r;
    r.temp = t; r.press = p; r.fault = f;
    return r;
  endfunction

  function automatic row_t mk(input int set, input logic [15:0] ut, input logic [18:0] up,
                              input bit typed, input reading_t want);
    row_t r;
    r.set = set; r.ut = ut; r.up = up; r.typed = typed; r.want = want;
    return r;
  endfunction

  // small random offset around a nominal calibration word
  function automatic logic [15:0] jitter(input logic [15:0] w, input int span);
    return w + 16'($urandom_range(0, 2 * span) - span);
  endfunction

  initial begin
    row_t        plan [$];
    reading_t    none;
    logic [31:0] regs [NUM_REGS];
    int          cur;
    bit          sane;
    logic [15:0] ut;
    logic [18:0] up;

    errors = 0; no_idle = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_bus.valid = 1'b0; in_bus.raw_temperature = '0; in_bus.raw_pressure = '0;
    foreach (coef[i]) coef[i] = '0;
    none = rd(0, 0, 1'b0);

    // zero, nominal, missing ac4, all ones, temperature overflow, mixed extremes
    coef_sets[0] = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    coef_sets[1] = '{32'h0198_FFB8, 32'hC7D1_7FE5, 32'h7FF5_5A71, 32'h182E_0004,
                     32'hDDF9_0B34};
    coef_sets[2] = '{32'h0198_FFB8, 32'hC7D1_0000, 32'h7FF5_5A71, 32'h182E_0004,
                     32'hDDF9_0B34};
    coef_sets[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF};
    coef_sets[4] = '{32'h0198_FFB8, 32'hC7D1_7FE5, 32'h0000_5A71, 32'h182E_0004,
                     32'h7FFF_0001};
    coef_sets[5] = '{32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h7FFF_8000,
                     32'h8000_7FFF};

    // zero divisor everywhere after reset
    plan.push_back(mk(0, 16'h0000, 19'h00000, 1, rd(0, 0, 1'b1)));
    plan.push_back(mk(0, 16'hFFFF, 19'h7FFFF, 1, rd(0, 0, 1'b1)));
    plan.push_back(mk(0, 16'h8000, 19'h40000, 1, rd(0, 0, 1'b1)));
    // the sensor's worked example: 15.0 C, 69964 Pa
    plan.push_back(mk(1, 16'd27898, 19'd23843, 1, rd(150, 69964, 1'b0)));
    plan.push_back(mk(1, 16'h0000, 19'h00000, 0, none));
    plan.push_back(mk(1, 16'hFFFF, 19'h7FFFF, 0, none));
    plan.push_back(mk(1, 16'h5A71, 19'h00000, 0, none));
    plan.push_back(mk(1, 16'hFFFF, 19'h00000, 0, none));
    plan.push_back(mk(1, 16'h0000, 19'h7FFFF, 0, none));
    // pressure divisor zero
    plan.push_back(mk(2, 16'd27898, 19'd23843, 1, rd(0, 0, 1'b1)));
    plan.push_back(mk(2, 16'hFFFF, 19'h7FFFF, 0, none));
    plan.push_back(mk(3, 16'h0000, 19'h00000, 0, none));
    plan.push_back(mk(3, 16'hFFFF, 19'h7FFFF, 0, none));
    plan.push_back(mk(3, 16'h1234, 19'h2AAAA, 0, none));
    plan.push_back(mk(4, 16'd27898, 19'd23843, 0, none));
    plan.push_back(mk(4, 16'hFFFF, 19'h7FFFF, 0, none));
    plan.push_back(mk(5, 16'h0000, 19'h7FFFF, 0, none));
    plan.push_back(mk(5, 16'hFFFF, 19'h00000, 0, none));
    plan.push_back(mk(5, 16'h8000, 19'h55555, 0, none));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    cur = 0;
    foreach (plan[i]) begin
      if (plan[i].set != cur) begin
        park_input();
        cur = plan[i].set;
        regs = coef_sets[cur];
        settle_and_load(regs);
      end
      send(plan[i].ut, plan[i].up, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      sane = (ph % 2 == 0) || ph == 7;
      for (int k = 0; k < NUM_REGS; k++) begin
        if (sane)
          regs[k] = {jitter(coef_sets[1][k][31:16], 300), jitter(coef_sets[1][k][15:0], 300)};
        else
          regs[k] = $urandom();
      end
      park_input();
      settle_and_load(regs);
      if (ph >= 6) no_idle = 1'b1;
      for (int n = 0; n < 100; n++) begin
        if (sane && $urandom_range(0, 4) != 0) begin
          ut = 16'($urandom_range(20000, 36000));
          up = 19'($urandom_range(15000, 45000) << OVERSAMPLING);
        end else begin
          ut = 16'($urandom_range(0, 65535));
          up = 19'($urandom_range(0, 524287));
        end
        send(ut, up, 1'b0, none);
      end
    end
    park_input();

    wait (pending.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
